/* rtl/lkvc_pkg.sv */
// Shared constants, types and operation codes of the LRU key-value cache.
package lkvc_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 32;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W = 5;

  localparam int CAP_MAX   = (MAX_ENTRIES < 31) ? MAX_ENTRIES : 31;
  localparam int CAP_RESET = (MAX_ENTRIES < 16) ? MAX_ENTRIES : 16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic                         operation;
    logic signed [KEY_BITS-1:0]   lookup_key;
    logic signed [VALUE_BITS-1:0] write_value;
  } cmd_t;

  typedef struct packed {
    logic                         hit;
    logic signed [VALUE_BITS-1:0] read_value;
  } result_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [IDX_W-1:0]      rank;
  } entry_t;

endpackage

/* rtl/lkvc_entry_ram.sv */
// Entry store: one read port and one write port, registered read data.
module lkvc_entry_ram (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [lkvc_pkg::IDX_W-1:0] rd_addr,
  output lkvc_pkg::entry_t          rd_data,
  input  logic                      wr_en,
  input  logic [lkvc_pkg::IDX_W-1:0] wr_addr,
  input  lkvc_pkg::entry_t          wr_data
);

  lkvc_pkg::entry_t mem [lkvc_pkg::MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/lru_key_value_cache.sv */
// Top level of the fully associative key-value cache with LRU replacement.
//
// A command word is taken when start is high and busy is low. Each command
// gives exactly one result word, shown on result for the single cycle in
// which done is high; the receiver cannot stall it, so it must take it then.
// Entries live in one memory that is swept once to find the key and the least
// recent entry, then, unless a get misses, swept again to update recency ranks,
// one entry a cycle through the memory's read port. The capacity register is
// written through cfg_write and cfg_data and only takes effect while the cache
// is empty.
module lru_key_value_cache (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  lkvc_pkg::cmd_t             cmd,
  output logic                       done,
  output lkvc_pkg::result_t          result,
  input  logic                       cfg_write,
  input  logic [lkvc_pkg::CAP_W-1:0] cfg_data
);

  localparam int IDX_W = lkvc_pkg::IDX_W;
  localparam int CNT_W = lkvc_pkg::CNT_W;
  localparam int CAP_W = lkvc_pkg::CAP_W;
  localparam int NE    = lkvc_pkg::MAX_ENTRIES;

  localparam logic [CNT_W-1:0] ADDR_END  = CNT_W'(NE);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(NE - 1);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    DECIDE,
    UPDATE
  } state_t;

  state_t                       state;
  logic [CNT_W-1:0]             addr;
  logic                         q_vld;
  logic [IDX_W-1:0]             q_slot;
  logic [NE-1:0]                valid;
  logic [CNT_W-1:0]             occupancy;
  logic [CAP_W-1:0]             capacity;
  lkvc_pkg::cmd_t               item;
  logic                         found;
  logic [IDX_W-1:0]             found_slot;
  logic [IDX_W-1:0]             found_rank;
  logic [lkvc_pkg::VALUE_BITS-1:0] found_value;
  logic [IDX_W-1:0]             lru_slot;
  logic [IDX_W-1:0]             target;
  lkvc_pkg::entry_t             tgt_word;
  logic [IDX_W-1:0]             thresh;
  logic                         incr_all;

  logic                         rd_en;
  logic [IDX_W-1:0]             rd_addr;
  lkvc_pkg::entry_t             q;
  logic                         wr_en;
  lkvc_pkg::entry_t             wr_data;
  logic                         accept;
  logic                         full;
  logic [NE-1:0]                avail;
  logic [IDX_W-1:0]             free_slot;
  logic                         q_match;
  logic [CAP_W-1:0]             cap_next;

  lkvc_entry_ram u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (q),
    .wr_en   (wr_en),
    .wr_addr (q_slot),
    .wr_data (wr_data)
  );

  assign busy   = (state != IDLE);
  assign accept = start && (state == IDLE);

  always_comb begin
    rd_en   = accept || (((state == SCAN) || (state == UPDATE)) && (addr != ADDR_END));
    rd_addr = (state == IDLE) ? '0 : addr[IDX_W-1:0];
  end

  assign q_match = valid[q_slot] && (q.key == item.lookup_key);
  assign full    = (occupancy != '0) && (32'(occupancy) >= 32'(capacity));

  always_comb begin
    avail = ~valid;
    if (full) begin
      avail[lru_slot] = 1'b1;
    end
    free_slot = '0;
    for (int i = NE - 1; i >= 0; i--) begin
      if (avail[i]) begin
        free_slot = IDX_W'(i);
      end
    end
  end

  always_comb begin
    wr_en   = (state == UPDATE) && q_vld;
    wr_data = q;
    if (q_slot == target) begin
      wr_data = tgt_word;
    end else if (valid[q_slot] && (incr_all || (q.rank < thresh))) begin
      wr_data.rank = q.rank + IDX_W'(1);
    end
  end

  always_comb begin
    if (cfg_data == '0) begin
      cap_next = CAP_W'(1);
    end else if (32'(cfg_data) > 32'(lkvc_pkg::CAP_MAX)) begin
      cap_next = CAP_W'(lkvc_pkg::CAP_MAX);
    end else begin
      cap_next = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      addr      <= '0;
      q_vld     <= 1'b0;
      valid     <= '0;
      occupancy <= '0;
      capacity  <= CAP_W'(lkvc_pkg::CAP_RESET);
      done      <= 1'b0;
    end else begin
      done   <= 1'b0;
      q_vld  <= rd_en;
      q_slot <= rd_addr;
      if (cfg_write && (occupancy == '0)) begin
        capacity <= cap_next;
      end
      unique case (state)
        IDLE: begin
          if (start) begin
            item  <= cmd;
            found <= 1'b0;
            addr  <= CNT_W'(1);
            state <= SCAN;
          end
        end
        SCAN: begin
          if (rd_en) begin
            addr <= addr + CNT_W'(1);
          end
          if (q_vld) begin
            if (q_match && !found) begin
              found       <= 1'b1;
              found_slot  <= q_slot;
              found_rank  <= q.rank;
              found_value <= q.value;
            end
            if (valid[q_slot] && (CNT_W'(q.rank) == occupancy - CNT_W'(1))) begin
              lru_slot <= q_slot;
            end
            if (q_slot == LAST_SLOT) begin
              state <= DECIDE;
            end
          end
        end
        DECIDE: begin
          done              <= 1'b1;
          result.hit        <= found;
          result.read_value <= '1;
          addr              <= '0;
          tgt_word.key      <= item.lookup_key;
          tgt_word.rank     <= '0;
          if (found) begin
            target   <= found_slot;
            thresh   <= found_rank;
            incr_all <= 1'b0;
            state    <= UPDATE;
            if (item.operation == lkvc_pkg::OP_GET) begin
              result.read_value <= found_value;
              tgt_word.value    <= found_value;
            end else begin
              tgt_word.value <= item.write_value;
            end
          end else if (item.operation == lkvc_pkg::OP_PUT) begin
            target         <= free_slot;
            thresh         <= '0;
            incr_all       <= 1'b1;
            tgt_word.value <= item.write_value;
            state          <= UPDATE;
            if (full) begin
              valid[lru_slot] <= 1'b0;
            end else begin
              occupancy <= occupancy + CNT_W'(1);
            end
            valid[free_slot] <= 1'b1;
          end else begin
            state <= IDLE;
          end
        end
        UPDATE: begin
          if (rd_en) begin
            addr <= addr + CNT_W'(1);
          end
          if (q_vld && (q_slot == LAST_SLOT)) begin
            addr  <= '0;
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

/* sim/lkvc_checker.sv */
// Checker that predicts and compares every result word of the LRU key-value cache.
`timescale 1ns / 100ps

module lkvc_checker
  import lkvc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  cmd_t                 cmd,
  input  logic                 done,
  input  result_t              result,
  input  logic                 cfg_write,
  input  logic [CAP_W-1:0]     cfg_data,
  output int                   answers_due,
  output int                   mismatch_count
);

  result_t               answer_q[$];
  logic                  slot_valid [MAX_ENTRIES];
  logic [KEY_BITS-1:0]   slot_key   [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] slot_value [MAX_ENTRIES];
  int                    slot_rank  [MAX_ENTRIES];
  int                    fill;
  int                    cap_limit;

  function automatic result_t predict_word(cmd_t c);
    result_t r;
    int      idx;
    int      slot;
    int      victim;
    int      old_rank;
    idx = -1;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (slot_valid[i] && slot_key[i] == c.lookup_key) idx = i;
    end
    r.hit = (idx >= 0);
    r.read_value = '1;
    if (idx >= 0) begin
      if (c.operation == OP_GET) begin
        r.read_value = slot_value[idx];
      end else begin
        slot_value[idx] = c.write_value;
      end
      old_rank = slot_rank[idx];
      for (int j = 0; j < MAX_ENTRIES; j++) begin
        if (slot_valid[j] && slot_rank[j] < old_rank) slot_rank[j]++;
      end
      slot_rank[idx] = 0;
    end else if (c.operation == OP_PUT) begin
      // Evict least recent entries until there is room under the capacity.
      while (fill > 0 && fill >= cap_limit) begin
        victim = -1;
        for (int j = MAX_ENTRIES - 1; j >= 0; j--) begin
          if (slot_valid[j] && slot_rank[j] == fill - 1) victim = j;
        end
        if (victim >= 0) slot_valid[victim] = 1'b0;
        fill--;
      end
      slot = -1;
      for (int j = MAX_ENTRIES - 1; j >= 0; j--) begin
        if (!slot_valid[j]) slot = j;
      end
      if (slot >= 0) begin
        for (int j = 0; j < MAX_ENTRIES; j++) begin
          if (slot_valid[j]) slot_rank[j]++;
        end
        slot_valid[slot] = 1'b1;
        slot_key[slot]   = c.lookup_key;
        slot_value[slot] = c.write_value;
        slot_rank[slot]  = 0;
        fill++;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    int      errs;
    int      v;
    errs = 0;
    if (rst) begin
      answer_q.delete();
      fill = 0;
      cap_limit = CAP_RESET;
      for (int i = 0; i < MAX_ENTRIES; i++) slot_valid[i] = 1'b0;
    end else begin
      // The capacity only takes a new value while the cache is empty.
      if (cfg_write && fill == 0) begin
        v = cfg_data;
        if (v < 1) v = 1;
        if (v > MAX_ENTRIES) v = MAX_ENTRIES;
        cap_limit = v;
      end
      if (done) begin
        if (answer_q.size() == 0) begin
          $error("result word with no command outstanding: hit %0d, read_value %0d",
                 result.hit, result.read_value);
          errs++;
        end else begin
          want = answer_q.pop_front();
          if (result.hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, result.hit);
            errs++;
          end
          if (result.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, result.read_value);
            errs++;
          end
        end
      end
      if (start && !busy) answer_q.push_back(predict_word(cmd));
    end
    answers_due <= answer_q.size();
    mismatch_count <= mismatch_count + errs;
  end

endmodule

/* sim/tb_lru_key_value_cache.sv */
// Testbench top that drives command words into the LRU key-value cache and gives the verdict.
`timescale 1ns / 100ps

module tb_lru_key_value_cache;
  import lkvc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_WORDS  = 240;
  localparam int POOL_SIZE    = 32;
  localparam int DRAIN_CYCLES = 40;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  cmd_t             cmd;
  logic             done;
  result_t          result;
  logic             cfg_write;
  logic [CAP_W-1:0] cfg_data;
  int               answers_due;
  int               mismatch_count;
  int               cycle_count;

  logic [KEY_BITS-1:0] key_pool [POOL_SIZE];
  int                  idle_plan [5] = '{0, 69, 18, 0, 69};
  int                  idle_pct;
  int                  pool_span;
  int                  cap_set;

  lru_key_value_cache u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  lkvc_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .cmd            (cmd),
    .done           (done),
    .result         (result),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .answers_due    (answers_due),
    .mismatch_count (mismatch_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_cmd(input logic op, input logic [KEY_BITS-1:0] key,
                          input logic [VALUE_BITS-1:0] val);
    cmd_t c;
    int   gap;
    c.operation   = op;
    c.lookup_key  = key;
    c.write_value = val;
    gap = 0;
    if ($urandom_range(99) < idle_pct) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      start <= 1'b0;
      do @(posedge clk); while (busy);
      repeat (gap - 1) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
  endtask

  task automatic random_cmd();
    logic                  op;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] val;
    op = 1'($urandom_range(1));
    if ($urandom_range(9) == 0) begin
      key = $urandom;
    end else begin
      key = key_pool[$urandom_range(pool_span - 1)];
    end
    case ($urandom_range(15))
      0:       val = 32'h8000_0000;
      1:       val = 32'h7FFF_FFFF;
      2:       val = '1;
      default: val = $urandom;
    endcase
    send_cmd(op, key, val);
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (answers_due != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cap(input logic [CAP_W-1:0] v);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [CAP_W-1:0] cap_raw;
    cycle_count = 0;
    rst       = 1'b1;
    start     = 1'b0;
    cmd       = '0;
    cfg_write = 1'b0;
    cfg_data  = '0;
    idle_pct  = 0;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = '0;
    key_pool[3] = '1;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Capacity writes while empty, including clamping of both extremes.
    write_cap(5'd0);
    send_cmd(OP_GET, 32'h0000_0000, 32'h0000_0000);
    send_cmd(OP_GET, 32'h8000_0000, 32'h1234_5678);
    start <= 1'b0;
    wait_idle();
    write_cap(5'd31);
    send_cmd(OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    start <= 1'b0;
    wait_idle();
    case ($urandom_range(2))
      0: begin
        cap_raw = CAP_W'($urandom_range(1));
        cap_set = 1;
      end
      1: begin
        cap_raw = CAP_W'($urandom_range(16, 31));
        cap_set = MAX_ENTRIES;
      end
      default: begin
        cap_raw = CAP_W'($urandom_range(2, 15));
        cap_set = int'(cap_raw);
      end
    endcase
    write_cap(cap_raw);

    send_cmd(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_cmd(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    send_cmd(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_cmd(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    send_cmd(OP_GET, 32'h8000_0000, 32'hA5A5_A5A5);
    send_cmd(OP_PUT, 32'h7FFF_FFFF, 32'h0000_0000);
    send_cmd(OP_GET, 32'h7FFF_FFFF, 32'h5A5A_5A5A);
    send_cmd(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_cmd(OP_PUT, 32'h0000_0000, 32'h5A5A_5A5A);
    for (int k = 1; k <= 9; k++) send_cmd(OP_PUT, k, ~k);
    send_cmd(OP_GET, 32'h0000_0001, 32'h0000_0000);
    send_cmd(OP_GET, 32'h8000_0000, 32'h0000_0000);
    start <= 1'b0;
    wait_idle();

    for (int p = 0; p < 5; p++) begin
      idle_pct  = idle_plan[p];
      pool_span = cap_set + $urandom_range(0, 8);
      if (pool_span < 2) pool_span = 2;
      if (pool_span > POOL_SIZE) pool_span = POOL_SIZE;
      for (int n = 0; n < PHASE_WORDS; n++) random_cmd();
      start <= 1'b0;
      wait_idle();
      // The cache is no longer empty, so these writes must have no effect.
      case (p)
        0:       write_cap(5'd0);
        1:       write_cap(5'd31);
        default: write_cap(CAP_W'($urandom_range(31)));
      endcase
    end

    while (answers_due != 0 || busy) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
